// ===== hdl/sensor_alarm_window_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor alarm window monitor
// Shorthand for the clocked, reset-gated checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SENSOR_ALARM_WINDOW_MONITOR_ASSERT_SVH
`define SENSOR_ALARM_WINDOW_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAWM_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("sensor alarm window monitor check failed");

// Consequent must hold in the cycle after the antecedent.
`define SAWM_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("sensor alarm window monitor check failed");

`endif

// ===== hdl/sawm_pkg.sv =====
// ----------------------------------------------------------------------------
// sawm_pkg
// Shared constants, types and register map of the sensor alarm window monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sawm_pkg;

  localparam int WINDOW_DEPTH = 10;
  localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W);
  localparam int FILL_W       = 5;
  localparam int STEP_W       = 5;
  localparam int LIMIT_W      = 4;
  localparam int COUNT_W      = 16;
  localparam int TDATA_W      = 80;
  localparam int ADDR_W       = 4;

  localparam logic signed [SAMPLE_W-1:0] ENTER_RESET = 16'sd5120;
  localparam logic signed [SAMPLE_W-1:0] ALERT_RESET = 16'sd7680;
  localparam logic signed [SAMPLE_W-1:0] CLEAR_RESET = 16'sd6400;
  localparam logic [LIMIT_W-1:0]         LIMIT_RESET = 4'd5;

  // Register index, taken from paddr[3:2].
  localparam logic [1:0] REG_ENTER = 2'd0;
  localparam logic [1:0] REG_ALERT = 2'd1;
  localparam logic [1:0] REG_CLEAR = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE        = 2'd0,
    MODE_MONITORING  = 2'd1,
    MODE_ALERT       = 2'd2,
    MODE_CALIBRATING = 2'd3
  } mode_t;

  // Result of one pass over the window.
  typedef struct packed {
    logic                       done;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] min;
    logic signed [SAMPLE_W-1:0] max;
    logic [CNT_W-1:0]           fill;
  } win_stat_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_res_t;

endpackage

// ===== hdl/sawm_window.sv =====
// ----------------------------------------------------------------------------
// sawm_window
// Sample ring with fill count, and a sequential sum, min and max scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sawm_window (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sawm_pkg::SAMPLE_W-1:0] sample,
  output sawm_pkg::win_stat_t                 stat
);
  import sawm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [WINDOW_DEPTH];
  logic [IDX_W-1:0]           write_position;
  logic [CNT_W-1:0]           valid_entries;

  logic                       busy;
  logic [IDX_W-1:0]           rd_idx;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       rd_vld;
  logic                       rd_first;
  logic                       rd_last;
  logic                       issue_last;

  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] min;
  logic signed [SAMPLE_W-1:0] max;
  logic                       done;

  assign issue_last = (rd_idx == IDX_W'(valid_entries - 1'b1));

  always_ff @(posedge clk) begin
    if (start) begin
      mem[write_position] <= sample;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      valid_entries  <= '0;
      busy           <= 1'b0;
      rd_idx         <= '0;
      rd_vld         <= 1'b0;
      rd_first       <= 1'b0;
      rd_last        <= 1'b0;
      done           <= 1'b0;
    end else begin
      done   <= rd_vld && rd_last;
      rd_vld <= busy;
      if (start) begin
        write_position <= (write_position == IDX_W'(WINDOW_DEPTH - 1)) ? '0
                                                                       : write_position + 1'b1;
        if (valid_entries != CNT_W'(WINDOW_DEPTH)) begin
          valid_entries <= valid_entries + 1'b1;
        end
        busy   <= 1'b1;
        rd_idx <= '0;
      end else if (busy) begin
        rd_first <= (rd_idx == '0);
        rd_last  <= issue_last;
        if (issue_last) begin
          busy <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
    end
  end

  // One add and two compares per beat of read data.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      if (rd_first) begin
        sum <= {{CNT_W{rd_data[SAMPLE_W-1]}}, rd_data};
        min <= rd_data;
        max <= rd_data;
      end else begin
        sum <= sum + {{CNT_W{rd_data[SAMPLE_W-1]}}, rd_data};
        if (rd_data < min) begin
          min <= rd_data;
        end
        if (rd_data > max) begin
          max <= rd_data;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.sum  = sum;
  assign stat.min  = min;
  assign stat.max  = max;
  assign stat.fill = valid_entries;

endmodule

// ===== hdl/sawm_div.sv =====
// ----------------------------------------------------------------------------
// sawm_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sawm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [sawm_pkg::SUM_W-1:0] dividend,
  input  logic [sawm_pkg::CNT_W-1:0]        divisor,
  output sawm_pkg::div_res_t                res
);
  import sawm_pkg::*;

  logic                 busy;
  logic                 done;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CNT_W-1:0]     den;
  logic [CNT_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W-1:0]     rem_next;
  logic [SUM_W-1:0]     quo_next;
  logic [SUM_W-1:0]     quo_signed;

  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
    quo_next = {quo[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      quo <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quo_signed   = neg ? (~quo + 1'b1) : quo;
  assign res.done     = done;
  assign res.quotient = quo_signed[SAMPLE_W-1:0];

endmodule

// ===== hdl/sensor_alarm_window_monitor.sv =====
// ----------------------------------------------------------------------------
// sensor_alarm_window_monitor
// Windowed sensor alarm machine with APB-style threshold registers.
// ----------------------------------------------------------------------------
// Input beats on s_* carry one signed Q8.8 sample in s_tdata[15:0]. Each
// sample is stored in a ring of WINDOW_DEPTH entries and the window is read
// back one entry per cycle to form its sum, minimum and maximum. In
// monitoring mode the average comes from a restoring divider that makes
// one quotient bit per cycle. s_tready rises with m_tvalid and is low
// while an item is in work. Each item yields one result beat on m_*, held
// in an output register: a new sample is taken while that beat waits, and
// a stalled receiver only holds the block at the end of the next item.
// Reset clears the mode, counters, fill count and the output valid, and
// loads the threshold registers with their defaults; no clearing pass is
// needed. The user must write the registers through the APB port only
// while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sensor_alarm_window_monitor_assert.svh"

module sensor_alarm_window_monitor (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: sample[15:0]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,
  // m_tdata: window_average[15:0], monitor_count[31:16],
  // cal_step[36:32], fill_count[41:37], window_min[57:42],
  // window_max[73:58], zero[79:74]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sawm_pkg::TDATA_W-1:0]  m_tdata,
  // m_tuser: mode_code[1:0]
  output logic [1:0]                    m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sawm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sawm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [SAMPLE_W-1:0] enter_threshold;
  logic signed [SAMPLE_W-1:0] alert_threshold;
  logic signed [SAMPLE_W-1:0] clear_threshold;
  logic [LIMIT_W-1:0]         calibration_limit;

  mode_t                      mode;
  mode_t                      mode_next;
  logic signed [SAMPLE_W-1:0] held_average;
  logic signed [SAMPLE_W-1:0] held_average_next;
  logic [COUNT_W-1:0]         sample_counter;
  logic [COUNT_W-1:0]         sample_counter_next;
  logic [STEP_W-1:0]          step_counter;
  logic [STEP_W-1:0]          step_counter_next;
  logic [STEP_W-1:0]          step_inc;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       in_beat;
  logic                       cfg_write;
  logic                       out_load;
  logic                       div_start;

  win_stat_t win_stat;
  div_res_t  div_res;

  assign in_beat   = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign div_start = (state == ST_SCAN) && win_stat.done && (mode == MODE_MONITORING);

  sawm_window u_window (
    .clk    (clk),
    .rst    (rst),
    .start  (in_beat),
    .sample (s_tdata),
    .stat   (win_stat)
  );

  sawm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (win_stat.sum),
    .divisor  (win_stat.fill),
    .res      (div_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enter_threshold   <= ENTER_RESET;
      alert_threshold   <= ALERT_RESET;
      clear_threshold   <= CLEAR_RESET;
      calibration_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_ENTER: enter_threshold   <= pwdata[15:0];
        REG_ALERT: alert_threshold   <= pwdata[15:0];
        REG_CLEAR: clear_threshold   <= pwdata[15:0];
        REG_LIMIT: calibration_limit <= pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENTER: prdata = {{16{enter_threshold[15]}}, enter_threshold};
      REG_ALERT: prdata = {{16{alert_threshold[15]}}, alert_threshold};
      REG_CLEAR: prdata = {{16{clear_threshold[15]}}, clear_threshold};
      REG_LIMIT: prdata = {{(32 - LIMIT_W){1'b0}}, calibration_limit};
    endcase
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (win_stat.done) begin
          state_next = (mode == MODE_MONITORING) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Alarm machine step, applied when the result is loaded.
  always_comb begin
    mode_next           = mode;
    held_average_next   = held_average;
    sample_counter_next = sample_counter;
    step_counter_next   = step_counter;
    step_inc            = step_counter + 1'b1;
    unique case (mode)
      MODE_IDLE: begin
        if (sample_q > enter_threshold) begin
          mode_next           = MODE_MONITORING;
          held_average_next   = sample_q;
          sample_counter_next = COUNT_W'(1);
        end
      end
      MODE_MONITORING: begin
        if (sample_counter != {COUNT_W{1'b1}}) begin
          sample_counter_next = sample_counter + 1'b1;
        end
        held_average_next = div_res.quotient;
        if (div_res.quotient > alert_threshold) begin
          mode_next           = MODE_ALERT;
          held_average_next   = '0;
          sample_counter_next = '0;
        end
      end
      MODE_ALERT: begin
        if (sample_q < clear_threshold) begin
          mode_next         = MODE_CALIBRATING;
          step_counter_next = STEP_W'(1);
        end
      end
      MODE_CALIBRATING: begin
        step_counter_next = step_inc;
        if (step_inc > {1'b0, calibration_limit}) begin
          mode_next         = MODE_IDLE;
          step_counter_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      mode           <= MODE_IDLE;
      held_average   <= '0;
      sample_counter <= '0;
      step_counter   <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        mode           <= mode_next;
        held_average   <= held_average_next;
        sample_counter <= sample_counter_next;
        step_counter   <= step_counter_next;
        m_tvalid       <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      sample_q <= s_tdata;
    end
    if (out_load) begin
      m_tuser <= mode_next;
      m_tdata <= {6'd0,
                  win_stat.max,
                  win_stat.min,
                  FILL_W'(win_stat.fill),
                  step_counter_next,
                  sample_counter_next,
                  held_average_next};
    end
  end

  `SAWM_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_beat, state == ST_SCAN)
  `SAWM_ASSERT_NEXT(a_done_loads_output, clk, rst, out_load, m_tvalid && (state == ST_IDLE))
  `SAWM_ASSERT_NOW(a_step_only_calibrating, clk, rst, mode != MODE_CALIBRATING,
                   step_counter == '0)
  `SAWM_ASSERT_NOW(a_count_only_monitoring, clk, rst, mode != MODE_MONITORING,
                   (sample_counter == '0) && (held_average == '0))
  `SAWM_ASSERT_NOW(a_div_only_monitoring, clk, rst, state == ST_DIV,
                   mode == MODE_MONITORING)

endmodule

// ===== tb/sensor_alarm_window_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_alarm_window_monitor_tb
// Self-checking bench for the windowed sensor alarm machine.
// A queue-fed driver sends Q8.8 samples with random gaps, and a monitor
// applies random back-pressure. A local model of the window ring and the
// four-mode alarm machine predicts each result beat, field by field. The
// thresholds and the calibration limit are reprogrammed between phases,
// the extremes among them.
// ----------------------------------------------------------------------------

module sensor_alarm_window_monitor_tb;
  import sawm_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    mode_t              mode;
    logic signed [15:0] average;
    logic [15:0]        count;
    logic [4:0]         step;
    logic [4:0]         fill;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } alarm_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic [1:0]          m_tuser;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [ADDR_W-1:0]   paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  sensor_alarm_window_monitor DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies and machine state of the local model.
  int    cfg_enter = 5120;
  int    cfg_alert = 7680;
  int    cfg_clear = 6400;
  int    cfg_limit = 5;
  mode_t alarm_mode = MODE_IDLE;
  int    win_buf [WINDOW_DEPTH];
  int    win_wr    = 0;
  int    win_fill  = 0;
  int    held_avg  = 0;
  int    mon_cnt   = 0;
  int    cal_step  = 0;

  logic [15:0]   pending_samples[$];
  alarm_result_t predicted_results[$];
  alarm_result_t want;
  int            errors      = 0;
  int            src_gap_max = 5;
  int            snk_gap_max = 5;
  int            src_wait    = 0;
  int            snk_wait    = 0;
  int            next_wait;
  int            idle_cycles = 0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic predict_alarm_step(input logic signed [15:0] smp);
    alarm_result_t r;
    int sum;
    int mn;
    int mx;
    if (win_wr >= WINDOW_DEPTH) win_wr = 0;
    win_buf[win_wr] = smp;
    win_wr = (win_wr + 1) % WINDOW_DEPTH;
    if (win_fill < WINDOW_DEPTH) win_fill++;
    sum = 0;
    mn = 0;
    mx = 0;
    for (int i = 0; i < win_fill; i++) begin
      sum += win_buf[i];
      if (i == 0 || win_buf[i] < mn) mn = win_buf[i];
      if (i == 0 || win_buf[i] > mx) mx = win_buf[i];
    end
    case (alarm_mode)
      MODE_IDLE: begin
        if (int'(smp) > cfg_enter) begin
          alarm_mode = MODE_MONITORING;
          held_avg = smp;
          mon_cnt = 1;
        end
      end
      MODE_MONITORING: begin
        if (mon_cnt < 65535) mon_cnt++;
        // Integer division truncates toward zero, as the block does.
        held_avg = sum / win_fill;
        if (held_avg > cfg_alert) begin
          alarm_mode = MODE_ALERT;
          held_avg = 0;
          mon_cnt = 0;
        end
      end
      MODE_ALERT: begin
        if (int'(smp) < cfg_clear) begin
          alarm_mode = MODE_CALIBRATING;
          cal_step = 1;
        end
      end
      default: begin
        cal_step++;
        if (cal_step > cfg_limit) begin
          alarm_mode = MODE_IDLE;
          cal_step = 0;
        end
      end
    endcase
    r.mode    = alarm_mode;
    r.average = held_avg[15:0];
    r.count   = mon_cnt[15:0];
    r.step    = cal_step[4:0];
    r.fill    = win_fill[4:0];
    r.lo      = mn[15:0];
    r.hi      = mx[15:0];
    predicted_results.push_back(r);
  endtask

  // Sample driver.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_alarm_step(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (src_wait != 0) begin
          src_wait <= src_wait - 1;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples.pop_front();
          src_wait <= $urandom_range(src_gap_max, 0);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_wait <= 0;
    end else begin
      next_wait = snk_wait;
      if (m_tvalid && m_tready) begin
        next_wait = $urandom_range(snk_gap_max, 0);
        if (predicted_results.size() == 0) begin
          flag_mismatch("result beat with no prediction waiting");
        end else begin
          want = predicted_results.pop_front();
          if (m_tuser !== want.mode)
            flag_mismatch($sformatf("mode_code got %0d expected %0d", m_tuser, want.mode));
          if (m_tdata[15:0] !== want.average)
            flag_mismatch($sformatf("window_average got %0d expected %0d",
                                    $signed(m_tdata[15:0]), want.average));
          if (m_tdata[31:16] !== want.count)
            flag_mismatch($sformatf("monitor_count got %0d expected %0d",
                                    m_tdata[31:16], want.count));
          if (m_tdata[36:32] !== want.step)
            flag_mismatch($sformatf("cal_step got %0d expected %0d",
                                    m_tdata[36:32], want.step));
          if (m_tdata[41:37] !== want.fill)
            flag_mismatch($sformatf("fill_count got %0d expected %0d",
                                    m_tdata[41:37], want.fill));
          if (m_tdata[57:42] !== want.lo)
            flag_mismatch($sformatf("window_min got %0d expected %0d",
                                    $signed(m_tdata[57:42]), want.lo));
          if (m_tdata[73:58] !== want.hi)
            flag_mismatch($sformatf("window_max got %0d expected %0d",
                                    $signed(m_tdata[73:58]), want.hi));
        end
      end
      if (next_wait != 0) begin
        m_tready <= 1'b0;
        snk_wait <= next_wait - 1;
      end else begin
        m_tready <= 1'b1;
        snk_wait <= 0;
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick(input int lo, input int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic signed [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENTER: cfg_enter = val;
      REG_ALERT: cfg_alert = val;
      REG_CLEAR: cfg_clear = val;
      default:   cfg_limit = val[3:0];
    endcase
  endtask

  task automatic program_thresholds(input int enter, input int alert, input int clr,
                                    input int limit);
    write_reg(REG_ENTER, enter[15:0]);
    write_reg(REG_ALERT, alert[15:0]);
    write_reg(REG_CLEAR, clr[15:0]);
    write_reg(REG_LIMIT, limit[15:0]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || predicted_results.size() != 0);
  endtask

  // Samples aimed at one pass through idle, monitoring, alert and
  // calibration, with random levels chosen around the current thresholds.
  task automatic push_alarm_episode();
    int n;
    n = pick(0, 3);
    repeat (n) pending_samples.push_back(16'(pick(-32768, cfg_enter)));
    if (cfg_enter < 32767) pending_samples.push_back(16'(pick(cfg_enter + 1, 32767)));
    n = pick(1, 12);
    repeat (n) begin
      if ($urandom_range(9, 0) < 7)
        pending_samples.push_back(16'(pick(cfg_alert, 32767)));
      else
        pending_samples.push_back(16'($urandom));
    end
    n = pick(0, 2);
    repeat (n) pending_samples.push_back(16'(pick(cfg_clear, 32767)));
    if (cfg_clear > -32768) pending_samples.push_back(16'(pick(-32768, cfg_clear - 1)));
    repeat (cfg_limit + 1) pending_samples.push_back(16'($urandom));
  endtask

  int ph_enter [5] = '{5120, -32768, 32767, 0, -256};
  int ph_alert [5] = '{7680, 32767, 0, 0, 256};
  int ph_clear [5] = '{6400, -32768, 0, 0, 128};
  int ph_limit [5] = '{5, 15, 1, 15, 3};
  int base;
  int e;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset thresholds: enter on a full-scale sample, an average that
    // truncates toward zero from a negative fraction, the alert, clear
    // exactly at and one below the threshold, the calibration run, and
    // an enter sample exactly at the threshold. The window wraps here.
    pending_samples = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd6400, 16'sd6399,
                        16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd5120, 16'sd5121,
                        -16'sd32768};
    wait_drained();

    // Calibration limit of zero: the first calibrating step returns to idle.
    program_thresholds(-32768, -32768, 32767, 0);
    pending_samples = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        -16'sd32768, 16'sd32767, -16'sd1, -16'sd32768};
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      if (p < 5) begin
        program_thresholds(ph_enter[p], ph_alert[p], ph_clear[p], ph_limit[p]);
      end else begin
        e = pick(-12000, 12000);
        program_thresholds(e, pick(e, 16000), pick(-16000, 16000), pick(0, 15));
      end
      src_gap_max = (p % 3 == 1) ? 0 : 5;
      snk_gap_max = (p % 3 == 2) ? 0 : 5;
      base = 0;
      while (base < 54) begin
        if ($urandom_range(4, 0) == 0) begin
          repeat (pick(1, 4)) pending_samples.push_back(16'($urandom));
        end else begin
          push_alarm_episode();
        end
        base = pending_samples.size();
      end
      wait_drained();
    end

    src_gap_max = 5;
    snk_gap_max = 5;
    repeat (60) @(posedge clk);
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
